>>> hdl/dvd_pkg.sv
// dvd_pkg: shared types, constants and the reciprocal seed table of the binary64 divider.
// Depends on nothing; every other file of the divider uses it by scoped names.
`timescale 1ns / 1ps

package dvd_pkg;

	localparam logic [10:0]        EXP_MAX     = 11'h7ff;
	localparam logic signed [12:0] EXP_BIAS    = 13'sd1023;
	localparam logic signed [12:0] EXP_TOP     = 13'sd2047;
	localparam logic signed [12:0] SUB_LIMIT   = 13'sd53;
	localparam logic [63:0]        INF_BITS    = 64'h7ff0000000000000;
	localparam logic [63:0]        QUIET_BIT   = 64'h0008000000000000;
	localparam logic [63:0]        DEFAULT_NAN = 64'hfff8000000000000;
	// low 46 stored fraction bits, inverted before the seed multiply
	localparam logic [52:0]        SEED_MASK   = 53'h00003fffffffffff;

	// result class decided after quotient normalization
	typedef enum logic [1:0] {
		CLS_NORM,
		CLS_OVF,
		CLS_ZERO,
		CLS_SUB
	} cls_t;

	// per-beat context carried alongside the multiplier chain
	typedef struct packed {
		logic              spec;
		logic [63:0]       spec_res;
		logic              sgn;
		logic [52:0]       ma;
		logic [52:0]       mb;
		logic signed [12:0] e;
		logic [63:0]       rc;
		logic [52:0]       q;
		logic [63:0]       aligned;
		cls_t              cls;
	} ctx_t;

	// multiply-accumulate state handed from cell to cell
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] acc;
		logic [63:0] lo;
	} mac_t;

	// 16-bit reciprocal seed, indexed by the top six stored fraction bits
	function automatic logic [15:0] seed_lookup(input logic [5:0] idx);
		logic [15:0] s;
		case (idx)
			6'd0: s = 16'hfc0f;  6'd1: s = 16'hf46b;  6'd2: s = 16'hed20;  6'd3: s = 16'he626;
			6'd4: s = 16'hdf7a;  6'd5: s = 16'hd918;  6'd6: s = 16'hd2fa;  6'd7: s = 16'hcd1e;
			6'd8: s = 16'hc77f;  6'd9: s = 16'hc21b;  6'd10: s = 16'hbcee; 6'd11: s = 16'hb7f5;
			6'd12: s = 16'hb32e; 6'd13: s = 16'hae96; 6'd14: s = 16'haa2a; 6'd15: s = 16'ha5e9;
			6'd16: s = 16'ha1d1; 6'd17: s = 16'h9dde; 6'd18: s = 16'h9a11; 6'd19: s = 16'h9665;
			6'd20: s = 16'h92dc; 6'd21: s = 16'h8f71; 6'd22: s = 16'h8c25; 6'd23: s = 16'h88f6;
			6'd24: s = 16'h85e2; 6'd25: s = 16'h82e8; 6'd26: s = 16'h8008; 6'd27: s = 16'h7d3f;
			6'd28: s = 16'h7a8e; 6'd29: s = 16'h77f2; 6'd30: s = 16'h756c; 6'd31: s = 16'h72f9;
			6'd32: s = 16'h709b; 6'd33: s = 16'h6e4e; 6'd34: s = 16'h6c14; 6'd35: s = 16'h69eb;
			6'd36: s = 16'h67d2; 6'd37: s = 16'h65c8; 6'd38: s = 16'h63cf; 6'd39: s = 16'h61e3;
			6'd40: s = 16'h6006; 6'd41: s = 16'h5e36; 6'd42: s = 16'h5c73; 6'd43: s = 16'h5abd;
			6'd44: s = 16'h5913; 6'd45: s = 16'h5774; 6'd46: s = 16'h55e1; 6'd47: s = 16'h5458;
			6'd48: s = 16'h52da; 6'd49: s = 16'h5166; 6'd50: s = 16'h4ffc; 6'd51: s = 16'h4e9b;
			6'd52: s = 16'h4d43; 6'd53: s = 16'h4bf3; 6'd54: s = 16'h4aad; 6'd55: s = 16'h496e;
			6'd56: s = 16'h4837; 6'd57: s = 16'h4708; 6'd58: s = 16'h45e0; 6'd59: s = 16'h44c0;
			6'd60: s = 16'h43a6; 6'd61: s = 16'h4293; 6'd62: s = 16'h4187; 6'd63: s = 16'h4081;
			default: s = 16'h4081;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/dvd_cell.sv
// dvd_cell: one multiply-accumulate cell, 64 x 16 bits per beat, of the product chain.
// Four cells in a row form a full 64 x 64 product. Depends on dvd_pkg.
`timescale 1ns / 1ps

module dvd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  dvd_pkg::mac_t  up_mac,
	input  dvd_pkg::ctx_t  up_ctx,
	output logic           dn_valid,
	input  logic           dn_ready,
	output dvd_pkg::mac_t  dn_mac,
	output dvd_pkg::ctx_t  dn_ctx
);

	logic           v_q;
	dvd_pkg::mac_t  mac_q;
	dvd_pkg::ctx_t  ctx_q;
	logic [79:0]    pp;
	logic [79:0]    sum;

	assign up_ready = !v_q || dn_ready;

	// one 16-bit digit of b times a, added to the running high part
	assign pp  = up_mac.a * up_mac.b[15:0];
	assign sum = {16'b0, up_mac.acc} + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	// low digit retires into lo, the rest shifts down for the next cell
	always_ff @(posedge clk) begin
		if (up_ready) begin
			mac_q.a   <= up_mac.a;
			mac_q.b   <= {16'b0, up_mac.b[63:16]};
			mac_q.acc <= sum[79:16];
			mac_q.lo  <= {sum[15:0], up_mac.lo[63:16]};
			ctx_q     <= up_ctx;
		end
	end

	assign dn_valid = v_q;
	assign dn_mac   = mac_q;
	assign dn_ctx   = ctx_q;

endmodule

>>> hdl/dvd_unpack.sv
// dvd_unpack: operand decode, special-case result, subnormal normalization and seed multiply.
// Three pipeline stages with per-stage ready. Depends on dvd_pkg.
`timescale 1ns / 1ps

module dvd_unpack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  logic [63:0]    dividend,
	input  logic [63:0]    divisor,
	output logic           dn_valid,
	input  logic           dn_ready,
	output dvd_pkg::ctx_t  dn_ctx
);

	// leading zeros of a nonzero 52-bit fraction
	function automatic logic [5:0] lead_zeros(input logic [51:0] f);
		logic [5:0] n;
		n = 6'd52;
		for (int i = 0; i < 52; i++) begin
			if (f[i]) begin
				n = 6'(51 - i);
			end
		end
		return n;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	// stage 1 signals
	logic        za, zb, nan_a, nan_b, inf_a, inf_b, spec, sgn;
	logic [63:0] spec_res;
	logic        sgn_s1, spec_s1;
	logic [63:0] res_s1;
	logic [10:0] ea_s1, eb_s1;
	logic [51:0] fa_s1, fb_s1;
	logic [5:0]  lza_s1, lzb_s1;

	// stage 2 signals
	logic [52:0]        ma, mb;
	logic signed [12:0] eas, ebs;
	logic               sgn_s2, spec_s2;
	logic [63:0]        res_s2;
	logic [52:0]        ma_s2, mb_s2;
	logic signed [12:0] e_s2;

	// stage 3 signals
	logic [47:0]   xm;
	logic [63:0]   rc0;
	dvd_pkg::ctx_t ctx_d;
	dvd_pkg::ctx_t ctx_s3;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// special operands: NaN, infinity, zero
	always_comb begin
		za    = (dividend[62:0] == 63'b0);
		zb    = (divisor[62:0] == 63'b0);
		nan_a = (dividend[62:0] > dvd_pkg::INF_BITS[62:0]);
		nan_b = (divisor[62:0] > dvd_pkg::INF_BITS[62:0]);
		inf_a = (dividend[62:0] == dvd_pkg::INF_BITS[62:0]);
		inf_b = (divisor[62:0] == dvd_pkg::INF_BITS[62:0]);
		sgn   = dividend[63] ^ divisor[63];
		spec  = (dividend[62:52] == dvd_pkg::EXP_MAX) || (divisor[62:52] == dvd_pkg::EXP_MAX)
			|| za || zb;
		if (nan_a) begin
			spec_res = dividend | dvd_pkg::QUIET_BIT;
		end else if (nan_b) begin
			spec_res = divisor | dvd_pkg::QUIET_BIT;
		end else if ((za && zb) || (inf_a && inf_b)) begin
			spec_res = dvd_pkg::DEFAULT_NAN;
		end else if (za || inf_b) begin
			spec_res = {sgn, 63'b0};
		end else begin
			spec_res = {sgn, 63'b0} | dvd_pkg::INF_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sgn_s1  <= sgn;
			spec_s1 <= spec;
			res_s1  <= spec_res;
			ea_s1   <= dividend[62:52];
			eb_s1   <= divisor[62:52];
			fa_s1   <= dividend[51:0];
			fb_s1   <= divisor[51:0];
			lza_s1  <= lead_zeros(dividend[51:0]);
			lzb_s1  <= lead_zeros(divisor[51:0]);
		end
	end

	// normalize subnormal significands and form the biased quotient exponent
	always_comb begin
		if (ea_s1 == 11'b0) begin
			ma  = {1'b0, fa_s1} << (lza_s1 + 6'd1);
			eas = -$signed({7'b0, lza_s1});
		end else begin
			ma  = {1'b1, fa_s1};
			eas = $signed({2'b0, ea_s1});
		end
		if (eb_s1 == 11'b0) begin
			mb  = {1'b0, fb_s1} << (lzb_s1 + 6'd1);
			ebs = -$signed({7'b0, lzb_s1});
		end else begin
			mb  = {1'b1, fb_s1};
			ebs = $signed({2'b0, eb_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sgn_s2  <= sgn_s1;
			spec_s2 <= spec_s1;
			res_s2  <= res_s1;
			ma_s2   <= ma;
			mb_s2   <= mb;
			e_s2    <= eas - ebs + dvd_pkg::EXP_BIAS;
		end
	end

	// seed times modified divisor significand
	always_comb begin
		xm       = 48'((mb_s2 ^ dvd_pkg::SEED_MASK) >> 5);
		rc0      = dvd_pkg::seed_lookup(mb_s2[51:46]) * xm;
		ctx_d    = '0;
		ctx_d.spec     = spec_s2;
		ctx_d.spec_res = res_s2;
		ctx_d.sgn      = sgn_s2;
		ctx_d.ma       = ma_s2;
		ctx_d.mb       = mb_s2;
		ctx_d.e        = e_s2;
		ctx_d.rc       = rc0;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctx_s3 <= ctx_d;
		end
	end

	assign dn_valid = v_s3;
	assign dn_ctx   = ctx_s3;

endmodule

>>> hdl/dvd_align.sv
// dvd_align: normalizes the raw quotient, classifies the result range and sets up the
// remainder operands for the back-multiply row. One pipeline stage. Depends on dvd_pkg.
`timescale 1ns / 1ps

module dvd_align (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  dvd_pkg::mac_t  up_mac,
	input  dvd_pkg::ctx_t  up_ctx,
	output logic           dn_valid,
	input  logic           dn_ready,
	output dvd_pkg::mac_t  dn_mac,
	output dvd_pkg::ctx_t  dn_ctx
);

	logic               v_s1;
	logic               ns;
	logic [52:0]        qn;
	logic [52:0]        q;
	logic signed [12:0] e2;
	logic signed [12:0] ds;
	logic [5:0]         sh;
	dvd_pkg::cls_t      cls;
	dvd_pkg::ctx_t      ctx_d;
	dvd_pkg::mac_t      mac_d;
	dvd_pkg::ctx_t      ctx_s1;
	dvd_pkg::mac_t      mac_s1;

	assign up_ready = !v_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	// quotient normalization and range split
	always_comb begin
		ns  = !up_mac.acc[52];
		qn  = ns ? {up_mac.acc[51:0], up_mac.lo[63]} : up_mac.acc[52:0];
		e2  = up_ctx.e - $signed({12'b0, ns});
		ds  = 13'sd1 - e2;
		q   = qn;
		sh  = 6'd0;
		cls = dvd_pkg::CLS_NORM;
		if (e2 > 13'sd0 && e2 < dvd_pkg::EXP_TOP) begin
			sh  = 6'(7'd53 + 7'(ns));
		end else if (e2 >= dvd_pkg::EXP_TOP) begin
			cls = dvd_pkg::CLS_OVF;
		end else if (ds > dvd_pkg::SUB_LIMIT) begin
			cls = dvd_pkg::CLS_ZERO;
		end else begin
			cls = dvd_pkg::CLS_SUB;
			q   = qn >> ds[5:0];
			sh  = 6'(7'd53 + 7'(ns) - 7'(ds[5:0]));
		end

		ctx_d         = up_ctx;
		ctx_d.e       = e2;
		ctx_d.q       = q;
		ctx_d.aligned = {11'b0, up_ctx.ma} << sh;
		ctx_d.cls     = cls;

		mac_d.a   = {10'b0, up_ctx.mb, 1'b0};
		mac_d.b   = {11'b0, q};
		mac_d.acc = 64'b0;
		mac_d.lo  = 64'b0;
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			ctx_s1 <= ctx_d;
			mac_s1 <= mac_d;
		end
	end

	assign dn_valid = v_s1;
	assign dn_ctx   = ctx_s1;
	assign dn_mac   = mac_s1;

endmodule

>>> hdl/dvd_round.sv
// dvd_round: remainder check, round-to-nearest-even increment and result packing.
// Four pipeline stages, the last one is the output register. Depends on dvd_pkg.
`timescale 1ns / 1ps

module dvd_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  dvd_pkg::mac_t  up_mac,
	input  dvd_pkg::ctx_t  up_ctx,
	output logic           dn_valid,
	input  logic           dn_ready,
	output logic [63:0]    quotient
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [63:0]   d2;
	logic [63:0]   rraw_s1, rinc_s1, mr_s2, mi_s2;
	logic [52:0]   q_s1, q_s2, q_s3;
	logic [10:0]   ef_s1, ef_s2, ef_s3;
	dvd_pkg::cls_t cls_s1, cls_s2, cls_s3;
	logic          sgn_s1, sgn_s2, sgn_s3;
	logic          spec_s1, spec_s2, spec_s3;
	logic [63:0]   res_s1, res_s2, res_s3;
	logic          inc, inc_s3;
	logic [63:0]   res_d, quotient_s4;

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// remainders for q and q + 1
	assign d2 = {10'b0, up_ctx.mb, 1'b0};

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			rraw_s1 <= up_ctx.aligned - up_mac.lo;
			rinc_s1 <= up_ctx.aligned - up_mac.lo - d2;
			q_s1    <= up_ctx.q;
			ef_s1   <= 11'(up_ctx.e[10:0] - 11'd1);
			cls_s1  <= up_ctx.cls;
			sgn_s1  <= up_ctx.sgn;
			spec_s1 <= up_ctx.spec;
			res_s1  <= up_ctx.spec_res;
		end
	end

	// magnitudes
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			mr_s2   <= rraw_s1[63] ? (64'd0 - rraw_s1) : rraw_s1;
			mi_s2   <= rinc_s1[63] ? (64'd0 - rinc_s1) : rinc_s1;
			q_s2    <= q_s1;
			ef_s2   <= ef_s1;
			cls_s2  <= cls_s1;
			sgn_s2  <= sgn_s1;
			spec_s2 <= spec_s1;
			res_s2  <= res_s1;
		end
	end

	// round up when q + 1 is nearer; subnormal ties go to even
	assign inc = (mi_s2 < mr_s2)
		|| (cls_s2 == dvd_pkg::CLS_SUB && mi_s2 == mr_s2 && q_s2[0]);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			inc_s3  <= inc;
			q_s3    <= q_s2;
			ef_s3   <= ef_s2;
			cls_s3  <= cls_s2;
			sgn_s3  <= sgn_s2;
			spec_s3 <= spec_s2;
			res_s3  <= res_s2;
		end
	end

	// pack the result
	always_comb begin
		case (cls_s3)
			dvd_pkg::CLS_NORM: res_d = {sgn_s3, 63'b0}
				| ({1'b0, ef_s3, 52'b0} + {11'b0, q_s3} + {63'b0, inc_s3});
			dvd_pkg::CLS_OVF:  res_d = {sgn_s3, 63'b0} | dvd_pkg::INF_BITS;
			dvd_pkg::CLS_ZERO: res_d = {sgn_s3, 63'b0};
			dvd_pkg::CLS_SUB:  res_d = {sgn_s3, 63'b0} | ({11'b0, q_s3} + {63'b0, inc_s3});
			default:           res_d = {sgn_s3, 63'b0};
		endcase
		if (spec_s3) begin
			res_d = res_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			quotient_s4 <= res_d;
		end
	end

	assign dn_valid = v_s4;
	assign quotient = quotient_s4;

endmodule

>>> hdl/binary64_float_divider_core.sv
// binary64_float_divider_core: pipelined binary64 divider, round to nearest even.
// Depends on dvd_pkg, dvd_unpack, dvd_cell, dvd_align and dvd_round.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------
//  req     | req_valid / req_ready | dividend[63:0], divisor[63:0]
//  rsp     | rsp_valid / rsp_ready | quotient[63:0]
//
// One beat is accepted per cycle while req_ready is high. The path holds 3 unpack/seed
// stages, 6 rows of 4 multiply cells (one 64 x 16 partial product each), 1 align stage,
// and 4 rounding stages. A cell advances one beat per cycle when its downstream is ready.
// Reset clears all stage valid bits; data registers are not reset.
// Every stage has its own ready, so a stalled rsp only blocks once all bubbles are filled.

module binary64_float_divider_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [63:0] quotient
);

	localparam int RowCount    = 6;
	localparam int CellsPerRow = 4;
	localparam int CellCount   = RowCount * CellsPerRow;

	logic                 unp_v, unp_rdy;
	dvd_pkg::ctx_t        unp_ctx;

	logic [CellCount-1:0] cv;
	logic [CellCount-1:0] cr;
	dvd_pkg::mac_t        cmac [CellCount];
	dvd_pkg::ctx_t        cctx [CellCount];

	logic                 rv   [RowCount];
	dvd_pkg::mac_t        rmac [RowCount];
	dvd_pkg::ctx_t        rctx [RowCount];
	logic                 rend_rdy [RowCount];

	logic                 aln_v, aln_rdy;
	dvd_pkg::mac_t        aln_mac;
	dvd_pkg::ctx_t        aln_ctx;
	logic                 rnd_rdy;

	// decode, normalize, seed
	dvd_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req_valid),
		.up_ready (req_ready),
		.dividend (dividend),
		.divisor  (divisor),
		.dn_valid (unp_v),
		.dn_ready (unp_rdy),
		.dn_ctx   (unp_ctx)
	);

	assign unp_rdy = cr[0];

	// row operands: two Newton-Raphson steps, the quotient product, then the back-multiply
	always_comb begin
		rv[0]          = unp_v;
		rctx[0]        = unp_ctx;
		rmac[0].a      = {unp_ctx.mb, 11'b0};
		rmac[0].b      = {unp_ctx.rc[62:0], 1'b0};
		rmac[0].acc    = 64'b0;
		rmac[0].lo     = 64'b0;

		// f = -p, times the current reciprocal
		rv[1]          = cv[CellsPerRow - 1];
		rctx[1]        = cctx[CellsPerRow - 1];
		rmac[1].a      = 64'd0 - cmac[CellsPerRow - 1].acc;
		rmac[1].b      = {cctx[CellsPerRow - 1].rc[62:0], 1'b0};
		rmac[1].acc    = 64'b0;
		rmac[1].lo     = 64'b0;

		// refined reciprocal times the divisor
		rv[2]          = cv[2 * CellsPerRow - 1];
		rctx[2]        = cctx[2 * CellsPerRow - 1];
		rctx[2].rc     = cmac[2 * CellsPerRow - 1].acc;
		rmac[2].a      = {cctx[2 * CellsPerRow - 1].mb, 11'b0};
		rmac[2].b      = {cmac[2 * CellsPerRow - 1].acc[62:0], 1'b0};
		rmac[2].acc    = 64'b0;
		rmac[2].lo     = 64'b0;

		rv[3]          = cv[3 * CellsPerRow - 1];
		rctx[3]        = cctx[3 * CellsPerRow - 1];
		rmac[3].a      = 64'd0 - cmac[3 * CellsPerRow - 1].acc;
		rmac[3].b      = {cctx[3 * CellsPerRow - 1].rc[62:0], 1'b0};
		rmac[3].acc    = 64'b0;
		rmac[3].lo     = 64'b0;

		// dividend significand times final reciprocal
		rv[4]          = cv[4 * CellsPerRow - 1];
		rctx[4]        = cctx[4 * CellsPerRow - 1];
		rctx[4].rc     = cmac[4 * CellsPerRow - 1].acc;
		rmac[4].a      = {11'b0, cctx[4 * CellsPerRow - 1].ma};
		rmac[4].b      = {cmac[4 * CellsPerRow - 1].acc[62:0], 1'b0};
		rmac[4].acc    = 64'b0;
		rmac[4].lo     = 64'b0;

		// back-multiply of the divisor by the quotient
		rv[5]          = aln_v;
		rctx[5]        = aln_ctx;
		rmac[5]        = aln_mac;
	end

	// ready seen at the end of each row
	always_comb begin
		for (int r = 0; r < RowCount - 2; r++) begin
			rend_rdy[r] = cr[(r + 1) * CellsPerRow];
		end
		rend_rdy[RowCount - 2] = aln_rdy;
		rend_rdy[RowCount - 1] = rnd_rdy;
	end

	// the cell chain
	for (genvar c = 0; c < CellCount; c++) begin : g_cell
		if (c % CellsPerRow == 0) begin : g_head
			dvd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (rv[c / CellsPerRow]),
				.up_ready (cr[c]),
				.up_mac   (rmac[c / CellsPerRow]),
				.up_ctx   (rctx[c / CellsPerRow]),
				.dn_valid (cv[c]),
				.dn_ready (cr[c + 1]),
				.dn_mac   (cmac[c]),
				.dn_ctx   (cctx[c])
			);
		end else if (c % CellsPerRow == CellsPerRow - 1) begin : g_tail
			dvd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (cv[c - 1]),
				.up_ready (cr[c]),
				.up_mac   (cmac[c - 1]),
				.up_ctx   (cctx[c - 1]),
				.dn_valid (cv[c]),
				.dn_ready (rend_rdy[c / CellsPerRow]),
				.dn_mac   (cmac[c]),
				.dn_ctx   (cctx[c])
			);
		end else begin : g_mid
			dvd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (cv[c - 1]),
				.up_ready (cr[c]),
				.up_mac   (cmac[c - 1]),
				.up_ctx   (cctx[c - 1]),
				.dn_valid (cv[c]),
				.dn_ready (cr[c + 1]),
				.dn_mac   (cmac[c]),
				.dn_ctx   (cctx[c])
			);
		end
	end

	// quotient normalization between the quotient row and the back-multiply row
	dvd_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cv[5 * CellsPerRow - 1]),
		.up_ready (aln_rdy),
		.up_mac   (cmac[5 * CellsPerRow - 1]),
		.up_ctx   (cctx[5 * CellsPerRow - 1]),
		.dn_valid (aln_v),
		.dn_ready (cr[5 * CellsPerRow]),
		.dn_mac   (aln_mac),
		.dn_ctx   (aln_ctx)
	);

	// rounding and output register
	dvd_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cv[CellCount - 1]),
		.up_ready (rnd_rdy),
		.up_mac   (cmac[CellCount - 1]),
		.up_ctx   (cctx[CellCount - 1]),
		.dn_valid (rsp_valid),
		.dn_ready (rsp_ready),
		.quotient (quotient)
	);

`ifndef SYNTHESIS
	// any empty cell in the chain must open the head of the chain
	a_chain_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cv != {CellCount{1'b1}}) |-> cr[0])
		else $error("cell chain has a bubble but its head is not ready");

	// a beat at the chain end that rounding cannot take stays put
	a_chain_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cv[CellCount - 1] && !rnd_rdy) |=> cv[CellCount - 1])
		else $error("beat lost at the end of the cell chain");

	// a NaN quotient is always quiet
	a_nan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && quotient[62:52] == dvd_pkg::EXP_MAX && quotient[51:0] != 52'b0)
		|-> quotient[51])
		else $error("signaling NaN produced");
`endif

endmodule

>>> sim/binary64_float_divider_core_test.sv
// Self-checking testbench of the pipelined binary64 divider core.
// Depends on dvd_pkg and binary64_float_divider_core; predicts each quotient in-line.
`timescale 1ns / 1ps

module binary64_float_divider_core_test;

	localparam int LATENCY     = 32;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [63:0] dividend;
	logic [63:0] divisor;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [63:0] quotient;

	logic [63:0] quot_pending[$];
	int          n_fail;
	int          n_sent;
	int          n_checked;
	int          idle_cycles;
	bit          hold_off;
	bit          stop_rx_gaps;

	binary64_float_divider_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.dividend  (dividend),
		.divisor   (divisor),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.quotient  (quotient)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reciprocal seed table, kept separate from the package copy
	function automatic logic [15:0] recip_seed(input logic [5:0] idx);
		logic [15:0] tab[64];
		tab = '{16'hfc0f, 16'hf46b, 16'hed20, 16'he626, 16'hdf7a, 16'hd918, 16'hd2fa, 16'hcd1e,
			16'hc77f, 16'hc21b, 16'hbcee, 16'hb7f5, 16'hb32e, 16'hae96, 16'haa2a, 16'ha5e9,
			16'ha1d1, 16'h9dde, 16'h9a11, 16'h9665, 16'h92dc, 16'h8f71, 16'h8c25, 16'h88f6,
			16'h85e2, 16'h82e8, 16'h8008, 16'h7d3f, 16'h7a8e, 16'h77f2, 16'h756c, 16'h72f9,
			16'h709b, 16'h6e4e, 16'h6c14, 16'h69eb, 16'h67d2, 16'h65c8, 16'h63cf, 16'h61e3,
			16'h6006, 16'h5e36, 16'h5c73, 16'h5abd, 16'h5913, 16'h5774, 16'h55e1, 16'h5458,
			16'h52da, 16'h5166, 16'h4ffc, 16'h4e9b, 16'h4d43, 16'h4bf3, 16'h4aad, 16'h496e,
			16'h4837, 16'h4708, 16'h45e0, 16'h44c0, 16'h43a6, 16'h4293, 16'h4187, 16'h4081};
		return tab[idx];
	endfunction

	function automatic logic [63:0] mul_hi(input logic [63:0] u, input logic [63:0] v);
		logic [127:0] prod;
		prod = {64'd0, u} * {64'd0, v};
		return prod[127:64];
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// expected quotient, round to nearest even
	function automatic logic [63:0] div_quotient(input logic [63:0] na, input logic [63:0] nb);
		logic [63:0] sgn, absa, absb, ma, mb, rc, z, p, f, lo, q, d2, rraw, rinc, aligned;
		logic [63:0] res;
		longint      ea, eb, e, ds;
		int          ns, inc, s;
		bit          za, zb, nan_a, nan_b, inf_a, inf_b;
		sgn = (na ^ nb) & 64'h8000000000000000;
		absa = {1'b0, na[62:0]};
		absb = {1'b0, nb[62:0]};
		ea = na[62:52];
		eb = nb[62:52];
		za = absa == 0;
		zb = absb == 0;
		if (ea == 2047 || eb == 2047 || za || zb) begin
			nan_a = absa > dvd_pkg::INF_BITS;
			inf_a = absa == dvd_pkg::INF_BITS;
			nan_b = absb > dvd_pkg::INF_BITS;
			inf_b = absb == dvd_pkg::INF_BITS;
			if (nan_a) res = na | dvd_pkg::QUIET_BIT;
			else if (nan_b) res = nb | dvd_pkg::QUIET_BIT;
			else if ((za && zb) || (inf_a && inf_b)) res = dvd_pkg::DEFAULT_NAN;
			else if (za || inf_b) res = sgn;
			else res = sgn | dvd_pkg::INF_BITS;
			return res;
		end
		ma = absa;
		mb = absb;
		// subnormal operands: shift the leading one up to the hidden position
		if (ea == 0) begin
			s = 0;
			while (!ma[52]) begin
				ma = ma << 1;
				s++;
			end
			ea = 1 - s;
		end
		if (eb == 0) begin
			s = 0;
			while (!mb[52]) begin
				mb = mb << 1;
				s++;
			end
			eb = 1 - s;
		end
		e = ea - eb + 1023;
		ma = {12'd1, ma[51:0]};
		mb = {12'd1, mb[51:0]};
		rc = recip_seed(mb[51:46]);
		rc = rc * ((mb ^ 64'h3fffffffffff) >> 5);
		z = mb << 11;
		// two refinement steps
		repeat (2) begin
			p = mul_hi(z, rc << 1);
			f = 64'd0 - p;
			rc = mul_hi(f, rc << 1);
		end
		lo = ma * (rc << 1);
		q = mul_hi(ma, rc << 1);
		ns = !q[52];
		e -= ns;
		if (ns) q = (q << 1) | (lo >> 63);
		d2 = mb << 1;
		if (e > 0 && e < 2047) begin
			aligned = ma << (53 + ns);
			rraw = aligned - d2 * q;
			rinc = rraw - d2;
			inc = abs64(rinc) < abs64(rraw);
			res = sgn | (((e - 1) << 52) + q + inc);
		end else if (e >= 2047) begin
			res = sgn | dvd_pkg::INF_BITS;
		end else begin
			ds = 1 - e;
			if (ds > 53) begin
				res = sgn;
			end else begin
				q = q >> ds;
				aligned = ma << (53 + ns - ds);
				rraw = aligned - d2 * q;
				rinc = rraw - d2;
				inc = (abs64(rinc) < abs64(rraw)) ||
					(abs64(rinc) == abs64(rraw) && q[0]);
				res = sgn | (q + inc);
			end
		end
		return res;
	endfunction

	// gap length: mostly short, a few long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one beat and record its expected quotient; valid stays up for a back-to-back beat
	task automatic send_div(input logic [63:0] a, input logic [63:0] b, input bit gaps);
		int g;
		g = gaps ? rand_gap() : 0;
		if (g != 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req_valid <= 1'b1;
		dividend <= a;
		divisor <= b;
		quot_pending.push_back(div_quotient(a, b));
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] make_fp(input bit sg, input logic [10:0] ex,
		input logic [51:0] fr);
		return {sg, ex, fr};
	endfunction

	// random fraction with the occasional all-ones, all-zeros or single-bit pattern
	function automatic logic [51:0] rand_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 52'd1 << $urandom_range(0, 51);
			default: return 52'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic test_specials();
		logic [63:0] one, two, snan, qnan, inf, maxn, minsub, minnorm;
		one = 64'h3ff0000000000000;
		two = 64'h4000000000000000;
		snan = 64'h7ff0000000000001;
		qnan = 64'hfff8000000000123;
		inf = dvd_pkg::INF_BITS;
		maxn = 64'h7fefffffffffffff;
		minsub = 64'h0000000000000001;
		minnorm = 64'h0010000000000000;
		send_div(snan, one, 0);
		send_div(one, snan | 64'h8000000000000000, 0);
		send_div(qnan, snan, 0);
		send_div(64'h0, 64'h8000000000000000, 0);
		send_div(inf, inf | 64'h8000000000000000, 0);
		send_div(64'h8000000000000000, two, 0);
		send_div(one, inf, 0);
		send_div(one, 64'h0, 0);
		send_div(inf, two, 0);
		send_div(maxn, minsub, 0);
		send_div(maxn, 64'h3fe0000000000000, 0);
		send_div(minsub, maxn, 0);
		send_div(minsub, two, 0);
		send_div(64'h0000000000000003, two, 0);
		send_div(minnorm, two, 0);
		send_div(minsub, minsub, 0);
		send_div(maxn, maxn, 0);
		send_div(64'hffffffffffffffff, one, 0);
		send_div(one, 64'h3ff0000000000003, 0);
		send_div(64'h400fffffffffffff, 64'h3fffffffffffffff, 0);
		send_div(64'h000fffffffffffff, 64'h3ff8000000000000, 0);
	endtask

	task automatic test_random_normal(input int n);
		repeat (n)
			send_div(make_fp(1'($urandom_range(0, 1)), 11'($urandom_range(1, 2046)),
				rand_frac()),
				make_fp(1'($urandom_range(0, 1)), 11'($urandom_range(1, 2046)),
				rand_frac()), 1);
	endtask

	// exponents near the overflow and underflow edges, subnormal operands, or any exponent
	task automatic test_random_edges(input int n);
		logic [10:0] xa, xb;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					xa = 11'($urandom_range(1900, 2046));
					xb = 11'($urandom_range(0, 150));
				end
				1: begin
					xa = 11'($urandom_range(0, 150));
					xb = 11'($urandom_range(970, 1100));
				end
				2: begin
					xa = 11'($urandom_range(0, 40));
					xb = 11'($urandom_range(0, 40));
				end
				default: begin
					xa = 11'($urandom_range(0, 2047));
					xb = 11'($urandom_range(0, 2047));
				end
			endcase
			send_div(make_fp(1'($urandom_range(0, 1)), xa, rand_frac()),
				make_fp(1'($urandom_range(0, 1)), xb, rand_frac()), 1);
		end
	endtask

	task automatic test_raw_bits(input int n);
		repeat (n)
			send_div({$urandom(), $urandom()}, {$urandom(), $urandom()}, 1);
	endtask

	// receiver holds off long while the sender streams back to back
	task automatic test_backpressure(input int n);
		hold_off = 1'b1;
		repeat (n)
			send_div(make_fp(1'($urandom_range(0, 1)), 11'($urandom_range(900, 1150)),
				rand_frac()),
				make_fp(1'($urandom_range(0, 1)), 11'($urandom_range(900, 1150)),
				rand_frac()), 0);
	endtask

	// receiver ready: random gaps, plus one long hold-off on request
	initial begin
		int g;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			g = stop_rx_gaps ? 0 : rand_gap();
			if (g == 0) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	// compare each returned beat with the oldest expectation
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (quot_pending.size() == 0) begin
				$error("quotient: unexpected beat, actual %h", quotient);
				n_fail++;
			end else begin
				want = quot_pending.pop_front();
				n_checked++;
				if (quotient !== want) begin
					$error("quotient: expected %h actual %h", want, quotient);
					n_fail++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int w;
		arst_n = 1'b0;
		req_valid = 1'b0;
		dividend = '0;
		divisor = '0;
		n_fail = 0;
		n_sent = 0;
		n_checked = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		stop_rx_gaps = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_specials();
		test_random_normal(800);
		test_backpressure(150);
		test_random_edges(600);
		test_raw_bits(350);
		req_valid <= 1'b0;

		// drain
		w = 0;
		while (quot_pending.size() != 0 && w < 100000) begin
			@(posedge clk);
			w++;
		end
		stop_rx_gaps = 1'b1;
		repeat (LATENCY + 8) @(posedge clk);
		$display("Sent %0d divisions (specials, normal, edge exponents, raw bits, stall),",
			n_sent);
		$display("checked %0d quotients, %0d left waiting.", n_checked, quot_pending.size());
		if (n_fail == 0 && quot_pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
